// ===== hw/rtl/rmps_pkg.sv =====
// Package for the range max prefix sum tree: constants, types and helpers.
`default_nettype none
package rmps_pkg;
   localparam int unsigned MaxElements = 1024;
   localparam int unsigned IdxWidth    = $clog2(MaxElements);
   localparam int unsigned LenWidth    = IdxWidth + 1;
   localparam int unsigned NodeCount   = 2 * MaxElements;
   localparam int unsigned NodeWidth   = $clog2(NodeCount);
   localparam int unsigned ValWidth    = 32;
   localparam int unsigned SumWidth    = 43;
   localparam int unsigned StackDepth  = 2 * (IdxWidth + 2);
   localparam int unsigned SpWidth     = $clog2(StackDepth + 1);

   localparam logic CmdLoad  = 1'b0;
   localparam logic CmdQuery = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LD_DOWN,
      ST_LD_UP_RD_L,
      ST_LD_UP_RD_R,
      ST_LD_UP_WR,
      ST_Q_POP,
      ST_Q_READ,
      ST_Q_MERGE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [NodeWidth-1:0] node;
      logic [IdxWidth-1:0]  span_s;
      logic [IdxWidth-1:0]  span_e;
   } frame_type;

   function automatic logic signed [SumWidth-1:0] smax(
      input logic signed [SumWidth-1:0] a,
      input logic signed [SumWidth-1:0] b);
      return (a > b) ? a : b;
   endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/range_max_prefix_sum_tree.sv =====
// Top level of the range max prefix sum tree with its node memory and sequencer.
`default_nettype none
// Segment tree over up to 1024 signed elements, stored in one node memory
// (sum and max prefix per node, one read or write per cycle, registered read
// data). After reset, and after every write of used_length, a clearing pass
// zeroes all 2048 node entries; no request is taken meanwhile. A load walks
// root to leaf one level at a time, writes the leaf, then climbs back with two
// reads and one write per level. A query walks the tree depth first over an
// explicit stack: ST_Q_POP pops each node, drops one outside the range, reads a
// covered one in ST_Q_READ, pushes a split one's children in ST_Q_MERGE;
// at most about 4*log2(used_length) nodes are visited. One request is worked
// at a time; the response register holds the result until taken.
module range_max_prefix_sum_tree
   import rmps_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_command,
   input  wire logic [IdxWidth-1:0]        req_element_index,
   input  wire logic signed [ValWidth-1:0] req_element_value,
   input  wire logic [IdxWidth-1:0]        req_range_low,
   input  wire logic [IdxWidth-1:0]        req_range_high,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed [SumWidth-1:0]      rsp_max_prefix,
   output logic signed [SumWidth-1:0]      rsp_range_sum,
   output logic                            rsp_status,
   input  wire logic                       csr_write_enable,
   input  wire logic [LenWidth-1:0]        csr_write_data
);
   logic [2*SumWidth-1:0] mem [NodeCount];
   logic [2*SumWidth-1:0] rd_data_ff;

   state_type state_ff, state_in;
   logic [LenWidth-1:0]  len_ff, len_in;
   logic [NodeWidth:0]   clr_ff, clr_in;
   logic [IdxWidth-1:0]  lo_ff, lo_in, hi_ff, hi_in, idx_ff, idx_in;
   logic signed [ValWidth-1:0] val_ff, val_in;
   logic [NodeWidth-1:0] node_ff, node_in;
   logic [IdxWidth-1:0]  s_ff, s_in, e_ff, e_in;
   logic [SpWidth-1:0]   sp_ff, sp_in;
   frame_type            stack_ff [StackDepth];
   logic                 push_a, push_b;
   frame_type            frame_a, frame_b;
   logic signed [SumWidth-1:0] lsum_ff, lsum_in, lmp_ff, lmp_in;
   logic signed [SumWidth-1:0] asum_ff, asum_in, amp_ff, amp_in;
   logic                 avalid_ff, avalid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [SumWidth-1:0] rsp_mp_ff, rsp_mp_in, rsp_sum_ff, rsp_sum_in;
   logic                 rsp_st_ff, rsp_st_in;

   logic                 mem_we, mem_re;
   logic [NodeWidth-1:0] mem_addr;
   logic [2*SumWidth-1:0] mem_wdata;
   logic [LenWidth-1:0]  act_len;
   logic [IdxWidth-1:0]  mid;
   logic [IdxWidth:0]    mid_sum;
   logic signed [SumWidth-1:0] rd_sum, rd_mp, new_sum;
   frame_type            top;

   always_comb begin
      if (len_ff == '0) begin
         act_len = LenWidth'(1);
      end else if (len_ff > LenWidth'(MaxElements)) begin
         act_len = LenWidth'(MaxElements);
      end else begin
         act_len = len_ff;
      end
   end

   assign rd_sum = rd_data_ff[2*SumWidth-1:SumWidth];
   assign rd_mp  = rd_data_ff[SumWidth-1:0];
   assign mid_sum = {1'b0, s_ff} + {1'b0, e_ff};
   assign mid = mid_sum[IdxWidth:1];
   assign top = stack_ff[sp_ff - SpWidth'(1)];
   assign new_sum = lsum_ff + rd_sum;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         len_ff       <= LenWidth'(MaxElements);
         clr_ff       <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         avalid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         clr_ff       <= clr_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
         avalid_ff    <= avalid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      idx_ff     <= idx_in;
      val_ff     <= val_in;
      node_ff    <= node_in;
      s_ff       <= s_in;
      e_ff       <= e_in;
      lsum_ff    <= lsum_in;
      lmp_ff     <= lmp_in;
      asum_ff    <= asum_in;
      amp_ff     <= amp_in;
      rsp_mp_ff  <= rsp_mp_in;
      rsp_sum_ff <= rsp_sum_in;
      rsp_st_ff  <= rsp_st_in;
      if (push_a) begin
         stack_ff[sp_ff] <= frame_a;
      end
      if (push_b) begin
         stack_ff[sp_ff + SpWidth'(1)] <= frame_b;
      end
   end

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      clr_in       = clr_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      node_in      = node_ff;
      s_in         = s_ff;
      e_in         = e_ff;
      sp_in        = sp_ff;
      lsum_in      = lsum_ff;
      lmp_in       = lmp_ff;
      asum_in      = asum_ff;
      amp_in       = amp_ff;
      avalid_in    = avalid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_mp_in    = rsp_mp_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_st_in    = rsp_st_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = node_ff;
      mem_wdata    = '0;
      push_a       = 1'b0;
      push_b       = 1'b0;
      frame_a      = '0;
      frame_b      = '0;
      req_ready    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff[NodeWidth-1:0];
            clr_in   = clr_ff + (NodeWidth+1)'(1);
            if (clr_ff == (NodeWidth+1)'(NodeCount - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               node_in = NodeWidth'(1);
               s_in    = '0;
               e_in    = IdxWidth'(act_len - LenWidth'(1));
               if (req_command == CmdLoad) begin
                  idx_in = req_element_index;
                  val_in = req_element_value;
                  if ({1'b0, req_element_index} < act_len) begin
                     state_in = ST_LD_DOWN;
                  end
               end else begin
                  lo_in = req_range_low;
                  hi_in = req_range_high;
                  if (req_range_low > req_range_high ||
                      {1'b0, req_range_high} >= act_len) begin
                     rsp_valid_in = 1'b1;
                     rsp_mp_in    = '0;
                     rsp_sum_in   = '0;
                     rsp_st_in    = 1'b1;
                     state_in     = ST_RESP;
                  end else begin
                     frame_a.node   = NodeWidth'(1);
                     frame_a.span_s = '0;
                     frame_a.span_e = IdxWidth'(act_len - LenWidth'(1));
                     push_a    = 1'b1;
                     sp_in     = SpWidth'(1);
                     avalid_in = 1'b0;
                     state_in  = ST_Q_POP;
                  end
               end
            end
         end
         ST_LD_DOWN: begin
            if (s_ff < e_ff) begin
               if (idx_ff <= mid) begin
                  node_in = {node_ff[NodeWidth-2:0], 1'b0};
                  e_in    = mid;
               end else begin
                  node_in = {node_ff[NodeWidth-2:0], 1'b1};
                  s_in    = mid + IdxWidth'(1);
               end
            end else begin
               mem_we    = 1'b1;
               mem_wdata = {SumWidth'(val_ff), SumWidth'(val_ff)};
               if (node_ff == NodeWidth'(1)) begin
                  state_in = ST_IDLE;
               end else begin
                  node_in  = node_ff >> 1;
                  state_in = ST_LD_UP_RD_L;
               end
            end
         end
         ST_LD_UP_RD_L: begin
            mem_re   = 1'b1;
            mem_addr = {node_ff[NodeWidth-2:0], 1'b0};
            state_in = ST_LD_UP_RD_R;
         end
         ST_LD_UP_RD_R: begin
            mem_re   = 1'b1;
            mem_addr = {node_ff[NodeWidth-2:0], 1'b1};
            lsum_in  = rd_sum;
            lmp_in   = rd_mp;
            state_in = ST_LD_UP_WR;
         end
         ST_LD_UP_WR: begin
            mem_we    = 1'b1;
            mem_wdata = {new_sum, smax(lmp_ff, lsum_ff + rd_mp)};
            if (node_ff == NodeWidth'(1)) begin
               state_in = ST_IDLE;
            end else begin
               node_in  = node_ff >> 1;
               state_in = ST_LD_UP_RD_L;
            end
         end
         ST_Q_POP: begin
            if (sp_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_mp_in    = amp_ff;
               rsp_sum_in   = asum_ff;
               rsp_st_in    = 1'b0;
               state_in     = ST_RESP;
            end else begin
               sp_in   = sp_ff - SpWidth'(1);
               node_in = top.node;
               s_in    = top.span_s;
               e_in    = top.span_e;
               if (lo_ff > top.span_e || hi_ff < top.span_s) begin
                  state_in = ST_Q_POP;
               end else if (top.span_s >= lo_ff && top.span_e <= hi_ff) begin
                  mem_re   = 1'b1;
                  mem_addr = top.node;
                  state_in = ST_Q_READ;
               end else begin
                  state_in = ST_Q_MERGE;
               end
            end
         end
         ST_Q_MERGE: begin
            // split: push right child first so the left one is visited first
            frame_a.node   = {node_ff[NodeWidth-2:0], 1'b1};
            frame_a.span_s = mid + IdxWidth'(1);
            frame_a.span_e = e_ff;
            frame_b.node   = {node_ff[NodeWidth-2:0], 1'b0};
            frame_b.span_s = s_ff;
            frame_b.span_e = mid;
            push_a   = 1'b1;
            push_b   = 1'b1;
            sp_in    = sp_ff + SpWidth'(2);
            state_in = ST_Q_POP;
         end
         ST_Q_READ: begin
            if (avalid_ff) begin
               asum_in = asum_ff + rd_sum;
               amp_in  = smax(amp_ff, asum_ff + rd_mp);
            end else begin
               asum_in = rd_sum;
               amp_in  = rd_mp;
            end
            avalid_in = 1'b1;
            state_in  = ST_Q_POP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_write_enable) begin
         len_in   = csr_write_data;
         clr_in   = '0;
         state_in = ST_CLEAR;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_max_prefix = rsp_mp_ff;
   assign rsp_range_sum  = rsp_sum_ff;
   assign rsp_status     = rsp_st_ff;

`ifndef SYNTH
   a_no_ready_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready)
      else $error("request taken during clear");
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SpWidth'(StackDepth))
      else $error("stack overflow");
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_max_prefix == '0 && rsp_range_sum == '0)
      else $error("error response carries data");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_range_sum))
      else $error("response dropped");
`endif
endmodule
`default_nettype wire

// ===== verif/range_max_prefix_sum_tree_checker.sv =====
// Checker for the range max prefix sum tree: watches the channels, predicts query responses, compares.
module range_max_prefix_sum_tree_checker
   import rmps_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic                       req_command,
   input  logic [IdxWidth-1:0]        req_element_index,
   input  logic signed [ValWidth-1:0] req_element_value,
   input  logic [IdxWidth-1:0]        req_range_low,
   input  logic [IdxWidth-1:0]        req_range_high,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic signed [SumWidth-1:0] rsp_max_prefix,
   input  logic signed [SumWidth-1:0] rsp_range_sum,
   input  logic                       rsp_status,
   input  logic                       csr_write_enable,
   input  logic [LenWidth-1:0]        csr_write_data,
   output int                         fail_count,
   output int                         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [SumWidth-1:0] max_prefix;
      logic signed [SumWidth-1:0] range_sum;
      logic                       status;
   } answer_type;

   logic signed [ValWidth-1:0] elements [MaxElements];
   int unsigned                tree_length;
   answer_type                 answers [$];

   assign pending = answers.size();

   function automatic int unsigned clamp_length(logic [LenWidth-1:0] v);
      if (v == 0) return 1;
      if (v > MaxElements) return MaxElements;
      return v;
   endfunction

   function automatic answer_type answer_query(int unsigned lo, int unsigned hi);
      answer_type a;
      longint     run;
      longint     best;
      run = 0;
      best = 0;
      a.status = 1'b0;
      if (lo > hi || hi >= tree_length) begin
         a.max_prefix = '0;
         a.range_sum = '0;
         a.status = 1'b1;
         return a;
      end
      for (int unsigned k = lo; k <= hi; k++) begin
         run += elements[k];
         if (k == lo || run > best) best = run;
      end
      a.max_prefix = best[SumWidth-1:0];
      a.range_sum = run[SumWidth-1:0];
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type got;
      answer_type want;
      if (reset) begin
         foreach (elements[i]) elements[i] = '0;
         tree_length = MaxElements;
         answers.delete();
         fail_count = 0;
      end else begin
         if (csr_write_enable) begin
            tree_length = clamp_length(csr_write_data);
            foreach (elements[i]) elements[i] = '0;
         end
         if (req_valid && req_ready) begin
            if (req_command == CmdLoad) begin
               if (req_element_index < tree_length)
                  elements[req_element_index] = req_element_value;
            end else begin
               answers.insert(answers.size(),
                              answer_query(req_range_low, req_range_high));
            end
         end
         if (rsp_valid && rsp_ready) begin
            got.max_prefix = rsp_max_prefix;
            got.range_sum = rsp_range_sum;
            got.status = rsp_status;
            if (answers.size() == 0) begin
               $display("%0t: unexpected response mp=%0d sum=%0d status=%0d",
                        $time, got.max_prefix, got.range_sum, got.status);
               fail_count++;
            end else begin
               want = answers.pop_front();
               if (got.max_prefix !== want.max_prefix) begin
                  $display("%0t: max_prefix expected %0d actual %0d",
                           $time, want.max_prefix, got.max_prefix);
                  fail_count++;
               end
               if (got.range_sum !== want.range_sum) begin
                  $display("%0t: range_sum expected %0d actual %0d",
                           $time, want.range_sum, got.range_sum);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, got.status);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

// ===== verif/range_max_prefix_sum_tree_tb.sv =====
// Testbench top for the range max prefix sum tree: clock, reset, request stimulus and verdict.
module range_max_prefix_sum_tree_tb
   import rmps_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int StallLimit = 20000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_command = CmdLoad;
   logic [IdxWidth-1:0]        req_element_index = '0;
   logic signed [ValWidth-1:0] req_element_value = '0;
   logic [IdxWidth-1:0]        req_range_low = '0;
   logic [IdxWidth-1:0]        req_range_high = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SumWidth-1:0] rsp_max_prefix;
   logic signed [SumWidth-1:0] rsp_range_sum;
   logic                       rsp_status;
   logic                       csr_write_enable = 1'b0;
   logic [LenWidth-1:0]        csr_write_data = '0;
   int                         fail_count;
   int                         pending;
   int                         idle_cycles = 0;
   int unsigned                cur_length = MaxElements;

   always #1 clock = ~clock;

   range_max_prefix_sum_tree dut (.*);
   range_max_prefix_sum_tree_checker checker_i (.*);

   // receiver: alternates between free-running and stalling stretches
   int stall_left = 0;
   int open_left = 0;
   always @(negedge clock) begin
      if (open_left > 0) begin
         open_left--;
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         open_left = $urandom_range(0, 40);
         stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 25) : 0;
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit) begin
         $display("range_max_prefix_sum_tree: mismatch");
         $finish;
      end
   end

   task automatic send_request(logic cmd, logic [IdxWidth-1:0] idx,
                               logic signed [ValWidth-1:0] val,
                               logic [IdxWidth-1:0] lo, logic [IdxWidth-1:0] hi);
      @(negedge clock);
      req_valid = 1'b1;
      req_command = cmd;
      req_element_index = idx;
      req_element_value = val;
      req_range_low = lo;
      req_range_high = hi;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic pause_sender(int n);
      @(negedge clock);
      req_valid = 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic drain_responses();
      pause_sender(1);
      while (pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic write_length(logic [LenWidth-1:0] v);
      drain_responses();
      csr_write_enable = 1'b1;
      csr_write_data = v;
      @(negedge clock);
      csr_write_enable = 1'b0;
      if (v == 0) cur_length = 1;
      else if (v > MaxElements) cur_length = MaxElements;
      else cur_length = v;
   endtask

   function automatic logic signed [ValWidth-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return $signed(32'($urandom_range(0, 20)) - 10);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_requests(int n);
      logic [IdxWidth-1:0] lo;
      logic [IdxWidth-1:0] hi;
      logic [IdxWidth-1:0] idx;
      int                  burst;
      burst = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
         idx = ($urandom_range(0, 9) == 0) ? IdxWidth'($urandom)
                                           : IdxWidth'($urandom_range(0, cur_length - 1));
         lo = IdxWidth'($urandom_range(0, cur_length - 1));
         hi = IdxWidth'($urandom_range(lo, cur_length - 1));
         if ($urandom_range(0, 9) == 0) begin
            lo = IdxWidth'($urandom);
            hi = IdxWidth'($urandom);
         end
         if ($urandom_range(0, 1) == 0)
            send_request(CmdLoad, idx, pick_value(), IdxWidth'($urandom),
                         IdxWidth'($urandom));
         else send_request(CmdQuery, IdxWidth'($urandom), $signed($urandom), lo, hi);
         if (--burst == 0) begin
            pause_sender($urandom_range(0, 15));
            burst = $urandom_range(1, 12);
         end
         if (i == n / 2 && n > 20) begin
            // hold until every outstanding response is back
            pause_sender(1);
            while (pending != 0) @(negedge clock);
         end
      end
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset = 1'b0;
      // directed requests at the reset length
      send_request(CmdQuery, 0, 0, 0, 1023);
      send_request(CmdLoad, 0, 32'sh7fffffff, 0, 0);
      send_request(CmdLoad, 1023, 32'sh80000000, 1023, 1023);
      send_request(CmdLoad, 512, -5, 0, 0);
      send_request(CmdQuery, 0, 0, 0, 1023);
      send_request(CmdQuery, 0, 0, 1023, 1023);
      send_request(CmdQuery, 0, 0, 600, 5);
      send_request(CmdQuery, 0, 0, 0, 0);
      send_request(CmdQuery, 1023, 32'sh7fffffff, 512, 1023);
      write_length(3);
      send_request(CmdLoad, 2, -7, 0, 0);
      send_request(CmdLoad, 3, 99, 0, 0);
      send_request(CmdLoad, 1023, 99, 0, 0);
      send_request(CmdQuery, 0, 0, 0, 2);
      send_request(CmdQuery, 0, 0, 0, 3);
      send_request(CmdQuery, 0, 0, 2, 1);
      write_length(0);
      send_request(CmdLoad, 0, 42, 0, 0);
      send_request(CmdQuery, 0, 0, 0, 0);
      send_request(CmdQuery, 0, 0, 0, 1);
      write_length(2047);
      send_request(CmdLoad, 1023, 1, 0, 0);
      send_request(CmdQuery, 0, 0, 0, 1023);
      // random phases, mostly short trees
      write_length(1);
      random_requests(40);
      write_length(2);
      random_requests(60);
      for (int p = 0; p < 8; p++) begin
         write_length($urandom_range(3, 64));
         random_requests(70);
      end
      write_length(1024);
      random_requests(150);
      drain_responses();
      if (fail_count == 0) $display("range_max_prefix_sum_tree: match");
      else $display("range_max_prefix_sum_tree: mismatch");
      $finish;
   end
endmodule

// ===== filelist.f =====
hw/rtl/rmps_pkg.sv
hw/rtl/range_max_prefix_sum_tree.sv
verif/range_max_prefix_sum_tree_checker.sv
verif/range_max_prefix_sum_tree_tb.sv
